/* rtl/bl2p_pkg.sv */
// Shared types, widths and register codes for the box to lidar point unit.
// No dependencies; compiled first.
package bl2p_pkg;

  localparam int unsigned PIXEL_BITS_DEF = 12;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 60;

  // register field widths
  localparam int unsigned FOCAL_W   = 18;
  localparam int unsigned PP_W      = 32;
  localparam int unsigned HGT_W     = 16;
  localparam int unsigned ROT_ROW_W = 54;
  localparam int unsigned ROT_W     = 18;
  localparam int unsigned TRANS_W   = 60;
  localparam int unsigned TR_W      = 20;

  // datapath widths
  localparam int unsigned HFY_W     = FOCAL_W + HGT_W;
  localparam int unsigned CAM_W     = 32;
  localparam int unsigned CT_W      = CAM_W + 1;
  localparam int unsigned PROD_W    = ROT_W + CT_W;
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned DIV_STEPS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X     = 4'd0,
    REG_FOCAL_Y     = 4'd1,
    REG_PRINC_POINT = 4'd2,
    REG_OBJ_HEIGHT  = 4'd3,
    REG_ROT_ROW0    = 4'd4,
    REG_ROT_ROW1    = 4'd5,
    REG_ROT_ROW2    = 4'd6,
    REG_TRANSLATION = 4'd7
  } cfg_reg_e;

  // register reset values
  localparam logic [FOCAL_W-1:0]   FOCAL_RST = 18'd16384;
  localparam logic [PP_W-1:0]      PP_RST    = 32'd0;
  localparam logic [HGT_W-1:0]     HGT_RST   = 16'd300;
  localparam logic [ROT_ROW_W-1:0] ROT0_RST  = 54'h0_0000_0001_0000;
  localparam logic [ROT_ROW_W-1:0] ROT1_RST  = 54'h0_0001_0000_0000;
  localparam logic [ROT_ROW_W-1:0] ROT2_RST  = 54'h1_0000_0000_0000;
  localparam logic [TRANS_W-1:0]   TRANS_RST = 60'd0;

  // per-item flags that ride alongside the divider pipeline
  typedef struct packed {
    logic neg0;
    logic neg1;
    logic fy_zero;
    logic height_zero;
    logic last;
  } side_t;

  // one finished result beat
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic [OUT_W-1:0]        depth;
    logic                    height_zero;
    logic                    frame_end;
  } point_t;

endpackage

/* rtl/bl2p_if.sv */
// Valid/ready channel interfaces for box beats in and point beats out.
// Depends on bl2p_pkg.
interface bl2p_box_if #(
  parameter int unsigned PIXEL_BITS = bl2p_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] box_left;
  logic [PIXEL_BITS-1:0] box_top;
  logic [PIXEL_BITS-1:0] box_right;
  logic [PIXEL_BITS-1:0] box_bottom;
  logic                  last_in_frame;

  modport source (output valid, box_left, box_top, box_right, box_bottom, last_in_frame,
                  input ready);
  modport sink   (input valid, box_left, box_top, box_right, box_bottom, last_in_frame,
                  output ready);
endinterface

interface bl2p_point_if;
  import bl2p_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] point_x;
  logic signed [OUT_W-1:0] point_y;
  logic signed [OUT_W-1:0] point_z;
  logic [OUT_W-1:0]        depth_mm;
  logic                    height_zero;
  logic                    frame_end;

  modport source (output valid, point_x, point_y, point_z, depth_mm, height_zero, frame_end,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, depth_mm, height_zero, frame_end,
                  output ready);
endinterface

/* rtl/box_to_lidar_point_unit.sv */
// Box to lidar point unit: one 3D lidar-frame point per detection box.
// Pipeline: front stages A to C, NS = ceil((max(PIXEL_BITS, 12) + 39) / 4) divider stages
//   in the pipelined divider, then back-end stages D to G in bl2p_rotate.
// Throughput: one box per cycle; a stalled output freezes the whole pipeline.
// Reset: async active low; clears all valid bits and loads register defaults.
// Depends on bl2p_pkg, bl2p_if, bl2p_div_pipe and bl2p_rotate.
module box_to_lidar_point_unit #(
  parameter int unsigned PIXEL_BITS = bl2p_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bl2p_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bl2p_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  bl2p_box_if.sink                          box_in,
  bl2p_point_if.source                      point_out
);
  import bl2p_pkg::*;

  localparam int unsigned U16_W  = PIXEL_BITS + 4;
  localparam int unsigned DX_W   = ((U16_W > 16) ? U16_W : 16) + 1;
  localparam int unsigned NUM_W  = DX_W + HFY_W;
  localparam int unsigned N1_W   = DX_W + HGT_W + 1;
  localparam int unsigned FXDH_W = FOCAL_W + PIXEL_BITS;
  localparam int unsigned DEN_W  = FXDH_W + 4;
  localparam int unsigned NS     = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

  // configuration registers
  logic [FOCAL_W-1:0]   focal_x_q, focal_y_q;
  logic [PP_W-1:0]      pp_q;
  logic [HGT_W-1:0]     hgt_q;
  logic [ROT_ROW_W-1:0] rot0_q, rot1_q, rot2_q;
  logic [TRANS_W-1:0]   trans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q <= FOCAL_RST;
      focal_y_q <= FOCAL_RST;
      pp_q      <= PP_RST;
      hgt_q     <= HGT_RST;
      rot0_q    <= ROT0_RST;
      rot1_q    <= ROT1_RST;
      rot2_q    <= ROT2_RST;
      trans_q   <= TRANS_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FOCAL_X:     focal_x_q <= cfg_wdata_i[FOCAL_W-1:0];
        REG_FOCAL_Y:     focal_y_q <= cfg_wdata_i[FOCAL_W-1:0];
        REG_PRINC_POINT: pp_q      <= cfg_wdata_i[PP_W-1:0];
        REG_OBJ_HEIGHT:  hgt_q     <= cfg_wdata_i[HGT_W-1:0];
        REG_ROT_ROW0:    rot0_q    <= cfg_wdata_i[ROT_ROW_W-1:0];
        REG_ROT_ROW1:    rot1_q    <= cfg_wdata_i[ROT_ROW_W-1:0];
        REG_ROT_ROW2:    rot2_q    <= cfg_wdata_i[ROT_ROW_W-1:0];
        REG_TRANSLATION: trans_q   <= cfg_wdata_i[TRANS_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless the output beat is stuck
  logic out_valid;
  logic adv;
  assign adv          = !out_valid || point_out.ready;
  assign box_in.ready = adv;

  // stage A: box height, centre offsets, H*fy
  logic [PIXEL_BITS-1:0]   dh_d, dh_a_q;
  logic [PIXEL_BITS:0]     usum, vsum;
  logic [U16_W-1:0]        u16, v16;
  logic signed [DX_W-1:0]  dx_d, dy_d, dx_a_q, dy_a_q;
  logic [HFY_W-1:0]        hfy_d, hfy_a_q;
  logic                    last_a_q, valid_a_q;

  always_comb begin
    dh_d  = (box_in.box_bottom >= box_in.box_top) ? box_in.box_bottom - box_in.box_top
                                                  : box_in.box_top - box_in.box_bottom;
    usum  = {1'b0, box_in.box_left} + {1'b0, box_in.box_right};
    vsum  = {1'b0, box_in.box_top} + {1'b0, box_in.box_bottom};
    u16   = {usum[PIXEL_BITS:1], 4'b0000};
    v16   = {vsum[PIXEL_BITS:1], 4'b0000};
    dx_d  = $signed(DX_W'(u16)) - $signed(DX_W'(pp_q[15:0]));
    dy_d  = $signed(DX_W'(v16)) - $signed(DX_W'(pp_q[31:16]));
    hfy_d = HFY_W'(hgt_q) * HFY_W'(focal_y_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dh_a_q   <= dh_d;
      dx_a_q   <= dx_d;
      dy_a_q   <= dy_d;
      hfy_a_q  <= hfy_d;
      last_a_q <= box_in.last_in_frame;
    end
  end

  // stage B: numerators and fx*dh
  logic [FOCAL_W-1:0]      fx_eff;
  logic signed [NUM_W:0]   num0_b_q;
  logic signed [N1_W-1:0]  num1_b_q;
  logic [FXDH_W-1:0]       fxdh_b_q;
  logic [PIXEL_BITS-1:0]   dh_b_q;
  logic [HFY_W-1:0]        hfy_b_q;
  logic                    last_b_q, valid_b_q;

  assign fx_eff = (focal_x_q == '0) ? FOCAL_W'(1) : focal_x_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num0_b_q <= (NUM_W+1)'(dx_a_q) * (NUM_W+1)'($signed({1'b0, hfy_a_q}));
      num1_b_q <= N1_W'(dy_a_q) * N1_W'($signed({1'b0, hgt_q}));
      fxdh_b_q <= FXDH_W'(fx_eff) * FXDH_W'(dh_a_q);
      dh_b_q   <= dh_a_q;
      hfy_b_q  <= hfy_a_q;
      last_b_q <= last_a_q;
    end
  end

  // stage C: magnitudes plus half divisor for round-half-away
  logic [NUM_W:0]       mag0;
  logic [N1_W-1:0]      mag1;
  logic [DEN_W-1:0]     den0_d;
  logic [NUM_W-1:0]     n0_c_q, n1_c_q, n2_c_q;
  logic [DEN_W-1:0]     den0_c_q, den12_c_q;
  side_t                side_c_d, side_c_q;
  logic                 valid_c_q;

  always_comb begin
    mag0   = num0_b_q[NUM_W] ? (NUM_W+1)'(-num0_b_q) : (NUM_W+1)'(num0_b_q);
    mag1   = num1_b_q[N1_W-1] ? N1_W'(-num1_b_q) : N1_W'(num1_b_q);
    den0_d = {fxdh_b_q, 4'b0000};
    side_c_d.neg0        = num0_b_q[NUM_W];
    side_c_d.neg1        = num1_b_q[N1_W-1];
    side_c_d.fy_zero     = (focal_y_q == '0);
    side_c_d.height_zero = (dh_b_q == '0);
    side_c_d.last        = last_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n0_c_q    <= mag0[NUM_W-1:0] + NUM_W'(den0_d >> 1);
      n1_c_q    <= NUM_W'(mag1) + NUM_W'({dh_b_q, 3'b000});
      n2_c_q    <= NUM_W'(hfy_b_q) + NUM_W'({dh_b_q, 3'b000});
      den0_c_q  <= den0_d;
      den12_c_q <= DEN_W'({dh_b_q, 4'b0000});
      side_c_q  <= side_c_d;
    end
  end

  // dividers
  logic [NUM_W-1:0] q0, q1, q2;

  bl2p_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div0 (
    .clk_i, .en_i(adv), .num_i(n0_c_q), .den_i(den0_c_q), .quo_o(q0)
  );
  bl2p_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div1 (
    .clk_i, .en_i(adv), .num_i(n1_c_q), .den_i(den12_c_q), .quo_o(q1)
  );
  bl2p_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div2 (
    .clk_i, .en_i(adv), .num_i(n2_c_q), .den_i(den12_c_q), .quo_o(q2)
  );

  // flags ride next to the divider stages
  side_t side_q  [NS];
  logic  valid_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[s] <= (s == 0) ? side_c_q : side_q[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (adv) begin
        valid_q[s] <= (s == 0) ? valid_c_q : valid_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  // front valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (adv) begin
      valid_a_q <= box_in.valid;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  // back end
  point_t point;

  bl2p_rotate #(.Q_W(NUM_W)) u_rotate (
    .clk_i,
    .rst_ni,
    .en_i       (adv),
    .valid_i    (valid_q[NS-1]),
    .side_i     (side_q[NS-1]),
    .q0_i       (q0),
    .q1_i       (q1),
    .q2_i       (q2),
    .rot_row0_i (rot0_q),
    .rot_row1_i (rot1_q),
    .rot_row2_i (rot2_q),
    .trans_i    (trans_q),
    .valid_o    (out_valid),
    .point_o    (point)
  );

  assign point_out.valid       = out_valid;
  assign point_out.point_x     = point.x;
  assign point_out.point_y     = point.y;
  assign point_out.point_z     = point.z;
  assign point_out.depth_mm    = point.depth;
  assign point_out.height_zero = point.height_zero;
  assign point_out.frame_end   = point.frame_end;

  // checks
  a_zero_height_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && point.height_zero |->
      point.x == '0 && point.y == '0 && point.z == '0 && point.depth == '0)
    else $error("height_zero beat carries nonzero point");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !point_out.ready |=> $stable(valid_a_q) && $stable(valid_c_q))
    else $error("pipeline moved during output stall");

  a_no_depth_without_fy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && focal_y_q == '0 |-> point.depth == '0)
    else $error("depth nonzero with zero focal_y");

endmodule

/* rtl/bl2p_div_pipe.sv */
// Pipelined restoring divider for unsigned operands, DIV_STEPS quotient bits per stage.
// Depends on bl2p_pkg.
module bl2p_div_pipe #(
  parameter int unsigned NUM_W = 51,
  parameter int unsigned DEN_W = 34
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);
  import bl2p_pkg::*;

  localparam int unsigned NS = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned PW = NS * DIV_STEPS;

  logic [DEN_W:0]   rem_q [NS];
  logic [PW-1:0]    quo_q [NS];
  logic [DEN_W-1:0] den_q [NS];
  logic [DEN_W:0]   rem_d [NS];
  logic [PW-1:0]    quo_d [NS];
  logic [DEN_W-1:0] den_in [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    // DIV_STEPS shift-subtract steps per stage
    always_comb begin
      logic [DEN_W:0]   rem;
      logic [PW-1:0]    quo;
      if (s == 0) begin
        rem       = '0;
        quo       = PW'(num_i);
        den_in[s] = den_i;
      end else begin
        rem       = rem_q[(s == 0) ? 0 : s-1];
        quo       = quo_q[(s == 0) ? 0 : s-1];
        den_in[s] = den_q[(s == 0) ? 0 : s-1];
      end
      for (int i = 0; i < DIV_STEPS; i++) begin
        rem = {rem[DEN_W-1:0], quo[PW-1]};
        quo = {quo[PW-2:0], 1'b0};
        if (rem >= {1'b0, den_in[s]}) begin
          rem    = rem - {1'b0, den_in[s]};
          quo[0] = 1'b1;
        end
      end
      rem_d[s] = rem;
      quo_d[s] = quo;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= den_in[s];
      end
    end
  end

  assign quo_o = quo_q[NS-1][NUM_W-1:0];

endmodule

/* rtl/bl2p_rotate.sv */
// Back end: camera point saturation, translation, inverse rotation, rounding.
// Four register stages; depends on bl2p_pkg.
module bl2p_rotate #(
  parameter int unsigned Q_W = 51
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  bl2p_pkg::side_t                           side_i,
  input  logic [Q_W-1:0]                            q0_i,
  input  logic [Q_W-1:0]                            q1_i,
  input  logic [Q_W-1:0]                            q2_i,
  input  logic [bl2p_pkg::ROT_ROW_W-1:0]            rot_row0_i,
  input  logic [bl2p_pkg::ROT_ROW_W-1:0]            rot_row1_i,
  input  logic [bl2p_pkg::ROT_ROW_W-1:0]            rot_row2_i,
  input  logic [bl2p_pkg::TRANS_W-1:0]              trans_i,
  output logic                                      valid_o,
  output bl2p_pkg::point_t                          point_o
);
  import bl2p_pkg::*;

  localparam logic signed [CAM_W-1:0] CAM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CAM_W-1:0] CAM_MIN = 32'sh8000_0000;
  localparam int unsigned RQ_W = ACC_W - 16;

  // stage D: saturate camera point, subtract translation
  logic [Q_W-1:0]          qv [3];
  logic signed [CT_W-1:0]  ct_d [3];
  logic signed [CT_W-1:0]  ct_q [3];
  logic [OUT_W-1:0]        depth_d, depth_d_q;
  side_t                   side_d_q;
  logic                    valid_d_q;

  assign qv[0] = q0_i;
  assign qv[1] = q1_i;
  assign qv[2] = q2_i;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic                    neg;
      logic signed [CAM_W-1:0] cam;
      logic signed [TR_W-1:0]  tr;
      neg = (j == 0) ? side_i.neg0 : ((j == 1) ? side_i.neg1 : 1'b0);
      if (neg) begin
        cam = (qv[j] > Q_W'(64'd2147483648)) ? CAM_MIN : -$signed(qv[j][CAM_W-1:0]);
      end else begin
        cam = (qv[j] > Q_W'(64'd2147483647)) ? CAM_MAX : $signed(qv[j][CAM_W-1:0]);
      end
      if (j == 1 && side_i.fy_zero) begin
        cam = '0;
      end
      tr      = $signed(trans_i[j*TR_W +: TR_W]);
      ct_d[j] = CT_W'(cam) - CT_W'(tr);
    end
    depth_d = (q2_i > Q_W'(64'd16777215)) ? '1 : q2_i[OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) ct_q[j] <= ct_d[j];
      depth_d_q <= depth_d;
      side_d_q  <= side_i;
    end
  end

  // stage E: nine products
  logic [ROT_ROW_W-1:0]      rows [3];
  logic signed [PROD_W-1:0]  prod_q [3][3];
  logic [OUT_W-1:0]          depth_e_q;
  side_t                     side_e_q;
  logic                      valid_e_q;

  assign rows[0] = rot_row0_i;
  assign rows[1] = rot_row1_i;
  assign rows[2] = rot_row2_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[k][j] <= PROD_W'($signed(rows[k][j*ROT_W +: ROT_W])) * PROD_W'(ct_q[j]);
        end
      end
      depth_e_q <= depth_d_q;
      side_e_q  <= side_d_q;
    end
  end

  // stage F: row sums
  logic signed [ACC_W-1:0] acc_q [3];
  logic [OUT_W-1:0]        depth_f_q;
  side_t                   side_f_q;
  logic                    valid_f_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= ACC_W'(prod_q[k][0]) + ACC_W'(prod_q[k][1]) + ACC_W'(prod_q[k][2]);
      end
      depth_f_q <= depth_e_q;
      side_f_q  <= side_e_q;
    end
  end

  // stage G: round Q.16 to integer, saturate, mask invalid boxes
  logic signed [OUT_W-1:0] crd_d [3];
  point_t                  point_d, point_q;
  logic                    valid_g_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic             neg;
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] mr;
      logic [RQ_W-1:0]  rq;
      neg = acc_q[k][ACC_W-1];
      mag = neg ? ACC_W'(-acc_q[k]) : ACC_W'(acc_q[k]);
      mr  = mag + ACC_W'(32768);
      rq  = mr[ACC_W-1:16];
      if (neg) begin
        crd_d[k] = (rq > RQ_W'(8388608)) ? 24'sh80_0000 : -$signed(rq[OUT_W-1:0]);
      end else begin
        crd_d[k] = (rq > RQ_W'(8388607)) ? 24'sh7F_FFFF : $signed(rq[OUT_W-1:0]);
      end
    end
    point_d.height_zero = side_f_q.height_zero;
    point_d.frame_end   = side_f_q.last;
    if (side_f_q.height_zero) begin
      point_d.x     = '0;
      point_d.y     = '0;
      point_d.z     = '0;
      point_d.depth = '0;
    end else begin
      point_d.x     = crd_d[0];
      point_d.y     = crd_d[1];
      point_d.z     = crd_d[2];
      point_d.depth = side_f_q.fy_zero ? '0 : depth_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      point_q <= point_d;
    end
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_d_q <= 1'b0;
      valid_e_q <= 1'b0;
      valid_f_q <= 1'b0;
      valid_g_q <= 1'b0;
    end else if (en_i) begin
      valid_d_q <= valid_i;
      valid_e_q <= valid_d_q;
      valid_f_q <= valid_e_q;
      valid_g_q <= valid_f_q;
    end
  end

  assign valid_o = valid_g_q;
  assign point_o = point_q;

endmodule

/* tb/sv/box_to_lidar_point_unit_test.sv */
// Self-checking testbench for box_to_lidar_point_unit: directed and random boxes,
// checked against a fixed-point back-projection predictor.
// Depends on bl2p_pkg, bl2p_if and the box_to_lidar_point_unit RTL.
`timescale 1ns / 100ps

module box_to_lidar_point_unit_test;
  import bl2p_pkg::*;

  localparam int unsigned PB          = PIXEL_BITS_DEF;
  localparam int          DRAIN_CYC   = 40;
  localparam int          STALL_LIMIT = 5000;
  localparam int          N_PHASES    = 8;
  localparam int          PHASE_ITEMS = 112;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd9;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  bl2p_box_if #(.PIXEL_BITS(PB)) box_ch ();
  bl2p_point_if point_ch ();

  box_to_lidar_point_unit #(.PIXEL_BITS(PB)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .box_in     (box_ch.sink),
    .point_out  (point_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // register shadow
  logic [FOCAL_W-1:0]   sh_fx, sh_fy;
  logic [PP_W-1:0]      sh_pp;
  logic [HGT_W-1:0]     sh_h;
  logic [ROT_ROW_W-1:0] sh_rot [3];
  logic [TRANS_W-1:0]   sh_trans;

  typedef struct {
    logic [PB-1:0] l, t, r, b;
    logic          last;
    bit            typed;
    point_t        pt;
  } box_row_t;

  box_row_t directed [$];
  point_t  pending_points [$];
  bit      typed_flags [$];
  point_t  typed_points [$];
  int      errors = 0;
  int      boxes_sent = 0;
  int      points_seen = 0;
  int      zero_boxes = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  int      hold_cycles = 0;
  int      quiet_cycles = 0;

  // round to nearest, ties away from zero; den > 0
  function automatic longint round_div(longint num, longint den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + longint'(den / 2)) / longint'(den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // expected point for one box under the current register shadow
  function automatic point_t project_box(logic [PB-1:0] l, t, r, b, logic last);
    point_t p;
    longint dh, fx, fy, h, cx, cy, u16, v16, acc, row;
    longint cam [3];
    p = '0;
    p.frame_end = last;
    dh = (b >= t) ? longint'(b) - longint'(t) : longint'(t) - longint'(b);
    if (dh == 0) begin
      p.height_zero = 1'b1;
      return p;
    end
    fx = (sh_fx == 0) ? 1 : longint'(sh_fx);
    fy = longint'(sh_fy);
    h = longint'(sh_h);
    cx = longint'(sh_pp[15:0]);
    cy = longint'(sh_pp[31:16]);
    u16 = 16 * ((longint'(l) + longint'(r)) >>> 1);
    v16 = 16 * ((longint'(t) + longint'(b)) >>> 1);
    if (fy == 0) begin
      cam[0] = 0; cam[1] = 0; cam[2] = 0;
    end else begin
      cam[0] = round_div((u16 - cx) * h * fy, fx * 16 * dh);
      cam[1] = round_div((v16 - cy) * h, 16 * dh);
      cam[2] = round_div(h * fy, 16 * dh);
      row = clip(cam[2], 0, 16777215);
      p.depth = row[OUT_W-1:0];
    end
    for (int j = 0; j < 3; j++) begin
      cam[j] = clip(cam[j], -64'sd2147483648, 64'sd2147483647);
      cam[j] -= longint'($signed(sh_trans[20*j +: TR_W]));
    end
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += longint'($signed(sh_rot[k][18*j +: ROT_W])) * cam[j];
      row = clip(round_div(acc, 65536), -8388608, 8388607);
      case (k)
        0: p.x = row[OUT_W-1:0];
        1: p.y = row[OUT_W-1:0];
        default: p.z = row[OUT_W-1:0];
      endcase
    end
    return p;
  endfunction

  // append one row to the directed table
  task automatic table_row(box_row_t r);
    directed = {directed, r};
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data[CFG_DATA_W-1:0];
    case (idx)
      REG_FOCAL_X:     sh_fx = data[FOCAL_W-1:0];
      REG_FOCAL_Y:     sh_fy = data[FOCAL_W-1:0];
      REG_PRINC_POINT: sh_pp = data[PP_W-1:0];
      REG_OBJ_HEIGHT:  sh_h = data[HGT_W-1:0];
      REG_ROT_ROW0:    sh_rot[0] = data[ROT_ROW_W-1:0];
      REG_ROT_ROW1:    sh_rot[1] = data[ROT_ROW_W-1:0];
      REG_ROT_ROW2:    sh_rot[2] = data[ROT_ROW_W-1:0];
      REG_TRANSLATION: sh_trans = data[TRANS_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drive one box beat and hold it until accepted
  task automatic send_box(box_row_t row);
    while ($urandom_range(99) < send_idle) begin
      box_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    typed_flags = {typed_flags, row.typed};
    if (row.typed) typed_points = {typed_points, row.pt};
    box_ch.valid <= 1'b1;
    box_ch.box_left <= row.l;
    box_ch.box_top <= row.t;
    box_ch.box_right <= row.r;
    box_ch.box_bottom <= row.b;
    box_ch.last_in_frame <= row.last;
    @(posedge clk_i);
    while (!box_ch.ready) @(posedge clk_i);
    boxes_sent++;
  endtask

  task automatic wait_drained();
    box_ch.valid <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random box: mostly arbitrary, some flat, some at the pixel extremes
  function automatic box_row_t rand_box();
    box_row_t row;
    int sel;
    row.typed = 0;
    row.pt = '0;
    row.last = 1'($urandom_range(1));
    row.l = PB'($urandom); row.t = PB'($urandom);
    row.r = PB'($urandom); row.b = PB'($urandom);
    sel = $urandom_range(99);
    if (sel < 10) row.b = row.t;
    else if (sel < 20) begin
      row.t = $urandom_range(1) ? '0 : '1;
      row.b = $urandom_range(1) ? '0 : '1;
      row.l = $urandom_range(1) ? '0 : '1;
    end else if (sel < 40) row.b = row.t + PB'($urandom_range(1, 8));
    return row;
  endfunction

  // input-side monitor: predict on each accepted box
  always @(posedge clk_i) begin
    point_t exp_pt;
    if (rst_ni && box_ch.valid && box_ch.ready) begin
      if (typed_flags.pop_front())
        exp_pt = typed_points.pop_front();
      else
        exp_pt = project_box(box_ch.box_left, box_ch.box_top,
                             box_ch.box_right, box_ch.box_bottom,
                             box_ch.last_in_frame);
      pending_points = {pending_points, exp_pt};
    end
  end

  // output-side monitor: compare each point beat with the oldest expectation
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && point_ch.valid && point_ch.ready) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        $error("point beat with no box outstanding");
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (want.height_zero) zero_boxes++;
        if (point_ch.point_x !== want.x) begin
          $error("point_x exp %0d got %0d", want.x, point_ch.point_x); errors++;
        end
        if (point_ch.point_y !== want.y) begin
          $error("point_y exp %0d got %0d", want.y, point_ch.point_y); errors++;
        end
        if (point_ch.point_z !== want.z) begin
          $error("point_z exp %0d got %0d", want.z, point_ch.point_z); errors++;
        end
        if (point_ch.depth_mm !== want.depth) begin
          $error("depth_mm exp %0d got %0d", want.depth, point_ch.depth_mm); errors++;
        end
        if (point_ch.height_zero !== want.height_zero) begin
          $error("height_zero exp %0b got %0b", want.height_zero, point_ch.height_zero);
          errors++;
        end
        if (point_ch.frame_end !== want.frame_end) begin
          $error("frame_end exp %0b got %0b", want.frame_end, point_ch.frame_end);
          errors++;
        end
      end
    end
  end

  // receiver: random back-pressure plus an optional long hold-off
  initial begin
    point_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        point_ch.ready <= 1'b0;
      end else begin
        point_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((box_ch.valid && box_ch.ready) || (point_ch.valid && point_ch.ready))
      quiet_cycles = 0;
    else if (++quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    box_row_t row;
    sh_fx = FOCAL_RST; sh_fy = FOCAL_RST; sh_pp = PP_RST; sh_h = HGT_RST;
    sh_rot[0] = ROT0_RST; sh_rot[1] = ROT1_RST; sh_rot[2] = ROT2_RST;
    sh_trans = TRANS_RST;
    box_ch.valid = 1'b0;
    box_ch.box_left = '0; box_ch.box_top = '0;
    box_ch.box_right = '0; box_ch.box_bottom = '0;
    box_ch.last_in_frame = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows under reset registers; typed where easy to read off
    table_row('{l: 0, t: 0, r: 0, b: 0, last: 0, typed: 1,
                pt: '{x: 0, y: 0, z: 0, depth: 0, height_zero: 1, frame_end: 0}});
    table_row('{l: 4095, t: 4095, r: 4095, b: 4095, last: 1, typed: 1,
                pt: '{x: 0, y: 0, z: 0, depth: 0, height_zero: 1, frame_end: 1}});
    table_row('{l: 0, t: 0, r: 0, b: 4095, last: 0, typed: 1,
                pt: '{x: 0, y: 38, z: 5, depth: 75, height_zero: 0, frame_end: 0}});
    table_row('{l: 0, t: 4095, r: 0, b: 0, last: 1, typed: 0, pt: '0});
    table_row('{l: 4095, t: 0, r: 4095, b: 1, last: 0, typed: 0, pt: '0});
    table_row('{l: 4095, t: 4094, r: 0, b: 4095, last: 1, typed: 0, pt: '0});
    table_row('{l: 1, t: 100, r: 2, b: 37, last: 0, typed: 0, pt: '0});
    table_row('{l: 2048, t: 2047, r: 2047, b: 2048, last: 0, typed: 0, pt: '0});
    table_row('{l: 4095, t: 0, r: 4094, b: 4095, last: 1, typed: 0, pt: '0});

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // back-pressure mode per phase
      if (ph < 3) begin send_idle = 19; recv_idle = 46; end
      else if (ph < 6) begin send_idle = 46; recv_idle = 19; end
      else begin send_idle = 0; recv_idle = 0; end
      case (ph)
        0: begin
          foreach (directed[i]) send_box(directed[i]);
        end
        1: begin  // register maxima, random rotation rows 1 and 2
          write_reg(REG_FOCAL_X, '1);
          write_reg(REG_FOCAL_Y, '1);
          write_reg(REG_PRINC_POINT, '1);
          write_reg(REG_OBJ_HEIGHT, '1);
          write_reg(REG_ROT_ROW0, '1);
          write_reg(REG_ROT_ROW1, rand64());
          write_reg(REG_ROT_ROW2, rand64());
          write_reg(REG_TRANSLATION, '1);
        end
        2: begin  // small values, focal_x of zero, unused index written
          write_reg(REG_FOCAL_X, 64'd0);
          write_reg(REG_FOCAL_Y, 64'd16);
          write_reg(REG_PRINC_POINT, 64'd0);
          write_reg(REG_OBJ_HEIGHT, 64'd1);
          write_reg(REG_ROT_ROW0, 64'd0);
          write_reg(REG_ROT_ROW1, 64'h0_0000_0001_0000);
          write_reg(REG_ROT_ROW2, 64'h2_0000_0000_0000);
          write_reg(REG_TRANSLATION, 64'h8_0000_8000_0800_00);
          write_reg(cfg_reg_e'(CFG_IDX_UNUSED), '1);
        end
        3: begin  // focal_y of zero
          write_reg(REG_FOCAL_Y, 64'd0);
          write_reg(REG_FOCAL_X, 64'($urandom_range(16, 262143)));
          write_reg(REG_TRANSLATION, rand64());
        end
        default: begin
          write_reg(REG_FOCAL_X, 64'($urandom_range(16, 262143)));
          write_reg(REG_FOCAL_Y, 64'($urandom_range(16, 262143)));
          write_reg(REG_PRINC_POINT, 64'($urandom));
          write_reg(REG_OBJ_HEIGHT, 64'($urandom_range(1, 65535)));
          write_reg(REG_ROT_ROW0, rand64());
          write_reg(REG_ROT_ROW1, rand64());
          write_reg(REG_ROT_ROW2, rand64());
          write_reg(REG_TRANSLATION, rand64());
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 6 && n == 10) hold_cycles = 300;
        row = rand_box();
        send_box(row);
      end
      wait_drained();
    end

    $display("Ran %0d boxes over %0d register settings; %0d points checked, %0d flat boxes.",
             boxes_sent, N_PHASES, points_seen, zero_boxes);
    if (errors == 0 && pending_points.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
